// ----- rtl/hhlp_pkg.sv -----
// Shared types and constants for the HTTP header line parser.
package hhlp_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int LIMIT_W     = 12;
    localparam int VALUE_LEN_W = 13;
    localparam int KEY_LEN_W   = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd255;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_KEY   = 3'd1,
        KIND_SEP   = 3'd2,
        KIND_VALUE = 3'd3,
        KIND_PAIR  = 3'd4,
        KIND_DONE  = 3'd5,
        KIND_BODY  = 3'd6,
        KIND_ERROR = 3'd7
    } byte_kind_t;

    typedef enum logic [3:0] {
        ST_LINE_START = 4'd0,
        ST_KEY        = 4'd1,
        ST_COLON      = 4'd2,
        ST_SPACE      = 4'd3,
        ST_VALUE      = 4'd4,
        ST_CR         = 4'd5,
        ST_LF         = 4'd6,
        ST_END_CR     = 4'd7,
        ST_BODY       = 4'd8,
        ST_ERROR      = 4'd9
    } parse_state_t;

    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic is_colon;
        logic is_space;
    } byte_class_t;

    typedef struct packed {
        logic        first;
        logic [7:0]  data;
        byte_class_t cls;
    } front_item_t;

    typedef struct packed {
        byte_kind_t             kind;
        logic [7:0]             echo;
        logic [KEY_LEN_W-1:0]   key_length;
        logic [VALUE_LEN_W-1:0] value_length;
    } result_t;

endpackage

// ----- rtl/hhlp_fifo.sv -----
// Small register-based FIFO with push/full and pop/empty sides.
module hhlp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/hhlp_front.sv -----
// Front stage: takes input bytes and registers them with their character class.
module hhlp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 first_of_request,
    input  logic [7:0]           data_byte,
    output logic                 q_push,
    output hhlp_pkg::front_item_t q_item,
    input  logic                 q_full
);

    logic                  valid_reg, valid_next;
    hhlp_pkg::front_item_t item_reg;
    hhlp_pkg::front_item_t item_in;
    logic                  take;

    assign full   = valid_reg && q_full;
    assign take   = push && !full;
    assign q_push = valid_reg;
    assign q_item = item_reg;

    always_comb
    begin
        item_in.first        = first_of_request;
        item_in.data         = data_byte;
        item_in.cls.is_cr    = (data_byte == hhlp_pkg::CHAR_CR);
        item_in.cls.is_lf    = (data_byte == hhlp_pkg::CHAR_LF);
        item_in.cls.is_colon = (data_byte == hhlp_pkg::CHAR_COLON);
        item_in.cls.is_space = (data_byte == hhlp_pkg::CHAR_SPACE);
        // hold while the queue refuses the staged item
        valid_next = take ? 1'b1 : (valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// ----- rtl/hhlp_back.sv -----
// Back stage: header grammar state machine, key/value counters, result forming.
module hhlp_back #(
    parameter int KEY_LENGTH_MAX = 255
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [hhlp_pkg::LIMIT_W-1:0]           limit,
    input  logic                                   q_empty,
    input  hhlp_pkg::front_item_t                  q_item,
    output logic                                   q_pop,
    input  logic                                   res_full,
    output logic                                   res_push,
    output hhlp_pkg::result_t                      res
);

    localparam int KEY_W  = $clog2(KEY_LENGTH_MAX + 1);
    localparam int KEXT_W = (KEY_W > 8) ? KEY_W : 8;
    localparam int VW     = hhlp_pkg::VALUE_LEN_W;

    hhlp_pkg::parse_state_t state_reg, state_next, state_cur;
    logic [KEY_W-1:0]       key_cnt_reg, key_cnt_next;
    logic [VW-1:0]          val_cnt_reg, val_cnt_next;
    logic [KEXT_W-1:0]      key_ext;
    hhlp_pkg::byte_class_t  cls;

    assign q_pop    = !q_empty && !res_full;
    assign res_push = q_pop;
    assign cls      = q_item.cls;
    assign key_ext  = KEXT_W'(key_cnt_reg);

    always_comb
    begin
        state_cur        = q_item.first ? hhlp_pkg::ST_LINE_START : state_reg;
        state_next       = state_cur;
        key_cnt_next     = q_item.first ? '0 : key_cnt_reg;
        val_cnt_next     = q_item.first ? '0 : val_cnt_reg;
        res.kind         = hhlp_pkg::KIND_ERROR;
        res.echo         = q_item.data;
        res.key_length   = '0;
        res.value_length = '0;

        unique case (state_cur)
            hhlp_pkg::ST_LINE_START:
            begin
                if (cls.is_cr || cls.is_lf)
                begin
                    res.kind = hhlp_pkg::KIND_SKIP;
                end
                else
                begin
                    key_cnt_next = KEY_W'(1);
                    state_next   = hhlp_pkg::ST_KEY;
                    res.kind     = hhlp_pkg::KIND_KEY;
                end
            end
            hhlp_pkg::ST_KEY:
            begin
                if (cls.is_colon)
                begin
                    state_next = hhlp_pkg::ST_COLON;
                    res.kind   = hhlp_pkg::KIND_SEP;
                end
                else if (cls.is_cr || cls.is_lf)
                begin
                    state_next = hhlp_pkg::ST_ERROR;
                end
                else
                begin
                    if (key_cnt_reg < KEY_W'(KEY_LENGTH_MAX))
                    begin
                        key_cnt_next = key_cnt_reg + 1'b1;
                    end
                    res.kind = hhlp_pkg::KIND_KEY;
                end
            end
            hhlp_pkg::ST_COLON:
            begin
                if (cls.is_space)
                begin
                    state_next = hhlp_pkg::ST_SPACE;
                    res.kind   = hhlp_pkg::KIND_SEP;
                end
                else
                begin
                    state_next = hhlp_pkg::ST_ERROR;
                end
            end
            hhlp_pkg::ST_SPACE:
            begin
                // first value byte is taken whatever it is
                val_cnt_next = VW'(1);
                state_next   = hhlp_pkg::ST_VALUE;
                res.kind     = hhlp_pkg::KIND_VALUE;
            end
            hhlp_pkg::ST_VALUE:
            begin
                if (cls.is_cr)
                begin
                    state_next = hhlp_pkg::ST_CR;
                    res.kind   = hhlp_pkg::KIND_SEP;
                end
                else if (val_cnt_reg > VW'(limit))
                begin
                    state_next = hhlp_pkg::ST_ERROR;
                end
                else
                begin
                    val_cnt_next = val_cnt_reg + 1'b1;
                    res.kind     = hhlp_pkg::KIND_VALUE;
                end
            end
            hhlp_pkg::ST_CR:
            begin
                if (cls.is_lf)
                begin
                    state_next       = hhlp_pkg::ST_LF;
                    res.kind         = hhlp_pkg::KIND_PAIR;
                    res.key_length   = (key_ext > KEXT_W'(255)) ? 8'hFF : key_ext[7:0];
                    res.value_length = val_cnt_reg;
                end
                else
                begin
                    state_next = hhlp_pkg::ST_ERROR;
                end
            end
            hhlp_pkg::ST_LF:
            begin
                if (cls.is_cr)
                begin
                    state_next = hhlp_pkg::ST_END_CR;
                    res.kind   = hhlp_pkg::KIND_SEP;
                end
                else
                begin
                    key_cnt_next = KEY_W'(1);
                    state_next   = hhlp_pkg::ST_KEY;
                    res.kind     = hhlp_pkg::KIND_KEY;
                end
            end
            hhlp_pkg::ST_END_CR:
            begin
                if (cls.is_lf)
                begin
                    state_next = hhlp_pkg::ST_BODY;
                    res.kind   = hhlp_pkg::KIND_DONE;
                end
                else
                begin
                    state_next = hhlp_pkg::ST_ERROR;
                end
            end
            hhlp_pkg::ST_BODY:
            begin
                res.kind = hhlp_pkg::KIND_BODY;
            end
            default:
            begin
                state_next = hhlp_pkg::ST_ERROR;
                res.kind   = hhlp_pkg::KIND_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hhlp_pkg::ST_LINE_START;
            key_cnt_reg <= '0;
            val_cnt_reg <= '0;
        end
        else if (q_pop)
        begin
            state_reg   <= state_next;
            key_cnt_reg <= key_cnt_next;
            val_cnt_reg <= val_cnt_next;
        end
    end

endmodule

// ----- rtl/http_header_line_parser.sv -----
// Top level of the HTTP header line parser: front stage, queue, back stage, result queue.
//
// Usage:
//   Input channel is queue-like: drive first_of_request/data_byte with push; a byte
//   transfers on a rising edge with push high and full low. Results come out of a
//   queue: while empty is low the oldest result sits on byte_kind, echo_byte,
//   key_length and value_length; it transfers on an edge with pop high.
//   Exactly one result per input byte, in input order.
//   Path: a transferred byte is registered in the front stage, passes the item queue,
//   and the grammar state machine then writes its result into the result queue.
//   Throughput: one byte per cycle while full stays low; the state machine and counters
//   update once per byte, with one compare/increment on the value counter in that path.
//   When pop stays low the two-entry result queue fills, the back stage stops,
//   the two-entry middle queue fills, and full rises; nothing is dropped.
//   cfg_we/cfg_wdata write value_length_limit; write only while the parser is idle.
//   Reset: queues empty, parser at line start, counters zero, limit 255.
module http_header_line_parser #(
    parameter int KEY_LENGTH_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        first_of_request,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  byte_kind,
    output logic [7:0]  echo_byte,
    output logic [7:0]  key_length,
    output logic [12:0] value_length,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    localparam int ITEM_W = $bits(hhlp_pkg::front_item_t);
    localparam int RES_W  = $bits(hhlp_pkg::result_t);

    logic [hhlp_pkg::LIMIT_W-1:0] limit_reg;

    logic                  q_push, q_full, q_pop, q_empty;
    hhlp_pkg::front_item_t q_wr_item, q_rd_item;
    logic [ITEM_W-1:0]     q_rdata;

    logic                  res_push, res_full;
    hhlp_pkg::result_t     res_in, res_out;
    logic [RES_W-1:0]      res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= hhlp_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    hhlp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .first_of_request (first_of_request),
        .data_byte        (data_byte),
        .q_push           (q_push),
        .q_item           (q_wr_item),
        .q_full           (q_full)
    );

    hhlp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wr_item),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign q_rd_item = hhlp_pkg::front_item_t'(q_rdata);

    hhlp_back #(
        .KEY_LENGTH_MAX (KEY_LENGTH_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .limit    (limit_reg),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    hhlp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out      = hhlp_pkg::result_t'(res_rdata);
    assign byte_kind    = res_out.kind;
    assign echo_byte    = res_out.echo;
    assign key_length   = res_out.key_length;
    assign value_length = res_out.value_length;

    // back stage never writes a result the queue cannot hold
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result written into a full queue");

    // a new request starting with a non-delimiter byte is always a key byte
    a_first_is_key: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_rd_item.first && !q_rd_item.cls.is_cr && !q_rd_item.cls.is_lf)
        |-> (res_in.kind == hhlp_pkg::KIND_KEY))
        else $error("first byte of request not classified as key");

    // lengths are reported only on a completed pair
    a_len_only_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_in.kind != hhlp_pkg::KIND_PAIR))
        |-> (res_in.value_length == '0 && res_in.key_length == '0))
        else $error("length reported outside a completed pair");

    // a result waiting at the head holds while not popped
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res_rdata)))
        else $error("queued result changed before transfer");

endmodule
